>>> hdl/u16u8_pkg.sv
`timescale 1ns / 1ps

package u16u8_pkg;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [20:0] REPL_CP     = 21'h00FFFD;
  localparam logic [20:0] MAX_CP      = 21'h10FFFF;
  localparam logic [15:0] SURR_LO     = 16'hD800;
  localparam logic [15:0] SURR_HI     = 16'hDFFF;
  // 0x10000 - 0xDC00
  localparam logic [21:0] PAIR_OFFSET = 22'h002400;

  // one code point to encode, plus an optional trailing replacement char
  typedef struct packed {
    logic [20:0] cp;
    logic        tail_repl;
    logic        eos;
  } cp_job_t;

  function automatic logic [2:0] utf8_len(input logic [20:0] cp);
    logic [2:0] n;
    if (cp <= 21'h00007F) begin
      n = 3'd1;
    end else if (cp <= 21'h0007FF) begin
      n = 3'd2;
    end else if (cp <= 21'h00FFFF) begin
      n = 3'd3;
    end else begin
      n = 3'd4;
    end
    return n;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp,
                                           input logic [2:0]  len,
                                           input logic [1:0]  idx);
    logic [7:0] b;
    b = {2'b10, cp[5:0]};
    unique case (len)
      3'd1: b = {1'b0, cp[6:0]};
      3'd2: begin
        unique case (idx)
          2'd0:    b = {3'b110, cp[10:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      3'd3: begin
        unique case (idx)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        unique case (idx)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

>>> hdl/u16u8_front.sv
`timescale 1ns / 1ps

module u16u8_front import u16u8_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_stream,
  output logic        job_valid,
  output cp_job_t     job
);

  logic [23:0] held_bytes_r, held_bytes_nxt;
  logic [1:0]  held_count_r, held_count_nxt;

  logic [15:0] unit_a;
  logic [15:0] unit_hi;
  logic [15:0] unit_lo;
  logic [21:0] pair_cp;
  logic        a_is_surr;

  assign unit_a    = {held_bytes_r[7:0], in_byte};
  assign a_is_surr = (unit_a >= SURR_LO) && (unit_a <= SURR_HI);
  assign unit_hi   = held_bytes_r[23:8];
  assign unit_lo   = {held_bytes_r[7:0], in_byte};
  // high unit is a surrogate here, so its offset is just its low 11 bits
  assign pair_cp   = {1'b0, unit_hi[10:0], 10'd0} + {6'd0, unit_lo} + PAIR_OFFSET;

  always_comb begin
    held_bytes_nxt = held_bytes_r;
    held_count_nxt = held_count_r;
    job_valid      = 1'b0;
    job.cp         = REPL_CP;
    job.tail_repl  = 1'b0;
    job.eos        = in_end_of_stream;
    unique case (held_count_r)
      2'd0: begin
        if (in_end_of_stream) begin
          job_valid = 1'b1;
        end else begin
          held_bytes_nxt = {16'd0, in_byte};
          held_count_nxt = 2'd1;
        end
      end
      2'd1: begin
        if (!a_is_surr || in_end_of_stream) begin
          job_valid      = 1'b1;
          job.cp         = {5'd0, unit_a};
          held_count_nxt = 2'd0;
        end else begin
          held_bytes_nxt = {8'd0, unit_a};
          held_count_nxt = 2'd2;
        end
      end
      2'd2: begin
        if (in_end_of_stream) begin
          job_valid      = 1'b1;
          job.cp         = {5'd0, held_bytes_r[15:0]};
          job.tail_repl  = 1'b1;
          held_count_nxt = 2'd0;
        end else begin
          held_bytes_nxt = {held_bytes_r[15:0], in_byte};
          held_count_nxt = 2'd3;
        end
      end
      default: begin
        job_valid      = 1'b1;
        job.cp         = (pair_cp > {1'b0, MAX_CP}) ? REPL_CP : pair_cp[20:0];
        held_count_nxt = 2'd0;
      end
    endcase
    if (in_end_of_stream) begin
      held_count_nxt = 2'd0;
    end
    job_valid = job_valid && accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_count_r <= 2'd0;
    end else if (accept) begin
      held_count_r <= held_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_bytes_r <= 24'd0;
    end else if (accept) begin
      held_bytes_r <= held_bytes_nxt;
    end
  end

endmodule

>>> hdl/u16u8_queue.sv
`timescale 1ns / 1ps

module u16u8_queue import u16u8_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_en,
  input  cp_job_t wr_job,
  input  logic    rd_en,
  output cp_job_t rd_job,
  output logic    not_empty,
  output logic    is_full
);

  cp_job_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;

  assign rd_job    = mem_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign is_full   = (count_r == QCNT_W'(QDEPTH));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> hdl/u16u8_back.sv
`timescale 1ns / 1ps

module u16u8_back import u16u8_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_avail,
  input  cp_job_t    job,
  output logic       job_take,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_utf8_byte,
  output logic       out_run_last,
  output logic       out_stream_done
);

  logic        phase_r;
  logic [1:0]  idx_r;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;
  logic        out_done_r;

  logic [20:0] cur_cp;
  logic [2:0]  cur_len;
  logic [2:0]  len_m1;
  logic        cp_last;
  logic        job_last;
  logic        advance;

  assign cur_cp   = phase_r ? REPL_CP : job.cp;
  assign cur_len  = utf8_len(cur_cp);
  assign len_m1   = cur_len - 3'd1;
  assign cp_last  = (idx_r == len_m1[1:0]);
  assign job_last = cp_last && (phase_r || !job.tail_repl);
  assign advance  = job_avail && (!out_valid_r || pop);
  assign job_take = advance && job_last;

  assign empty           = !out_valid_r;
  assign out_utf8_byte   = out_byte_r;
  assign out_run_last    = out_last_r;
  assign out_stream_done = out_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
        if (cp_last) begin
          idx_r   <= 2'd0;
          phase_r <= !job_last;
        end else begin
          idx_r <= idx_r + 2'd1;
        end
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_r <= utf8_byte(cur_cp, cur_len, idx_r);
      out_last_r <= job_last;
      out_done_r <= job_last && job.eos;
    end
  end

endmodule

>>> hdl/utf16be_to_utf8_transcoder.sv
`timescale 1ns / 1ps
// utf-16be byte stream in, utf-8 bytes out, one byte per cycle on each side while not stalled
// path: a finished code point's job goes into the job queue, then its bytes are registered out
// throughput: one input byte per cycle while the job queue has room; one output byte per
//   cycle, set by the byte-serial encoder, while a job is queued and the receiver pops;
//   a code point yields 1 to 4 bytes (up to 6 when a trailing replacement char follows)
// reset: synchronous active-low rst_n empties the queue, drops held bytes and the output item

module utf16be_to_utf8_transcoder import u16u8_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  // input queue side
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_stream,
  // result queue side
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_utf8_byte,
  output logic       out_run_last,
  output logic       out_stream_done
);

  // front: pairs bytes into units, joins surrogate pairs, yields one job per code point
  logic    accept;
  logic    front_valid;
  cp_job_t front_job;

  // queue between front and encoder
  cp_job_t head_job;
  logic    head_valid;
  logic    q_full;
  logic    head_take;

  // full is conservative: the front may need a queue slot for any item
  assign full   = q_full;
  assign accept = push && !q_full;

  u16u8_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (accept),
    .in_byte          (in_byte),
    .in_end_of_stream (in_end_of_stream),
    .job_valid        (front_valid),
    .job              (front_job)
  );

  u16u8_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (front_valid),
    .wr_job    (front_job),
    .rd_en     (head_take),
    .rd_job    (head_job),
    .not_empty (head_valid),
    .is_full   (q_full)
  );

  // back: serializes each job into utf-8 bytes through a registered output item
  u16u8_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_avail       (head_valid),
    .job             (head_job),
    .job_take        (head_take),
    .empty           (empty),
    .pop             (pop),
    .out_utf8_byte   (out_utf8_byte),
    .out_run_last    (out_run_last),
    .out_stream_done (out_stream_done)
  );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  // code points the encoder treats specially
  localparam logic [21:0] REPLACEMENT = 22'h00FFFD;
  localparam logic [21:0] MAX_SCALAR  = 22'h10FFFF;
  localparam logic [15:0] HIGH_FIRST  = 16'hD800;
  localparam logic [15:0] SURR_LAST   = 16'hDFFF;
  localparam logic [21:0] PAIR_ADJUST = 22'h002400;  // 0x10000 - 0xDC00
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          TAIL_CYCLES = 40;

  typedef struct {
    logic [7:0] b;
    logic       eos;
    logic       drain;  // hold this item back until every utf-8 byte is out
  } u16_byte_t;

  typedef struct {
    logic [7:0] b;
    logic       run_last;
    logic       stream_done;
  } utf8_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte = 8'h00;
  logic       in_end_of_stream = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_utf8_byte;
  logic       out_run_last;
  logic       out_stream_done;

  utf16be_to_utf8_transcoder uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_byte         (in_byte),
    .in_end_of_stream(in_end_of_stream),
    .empty           (empty),
    .pop             (pop),
    .out_utf8_byte   (out_utf8_byte),
    .out_run_last    (out_run_last),
    .out_stream_done (out_stream_done)
  );

  // utf-16be bytes waiting to be driven, utf-8 bytes waiting to come out
  u16_byte_t  u16_stream_q[$];
  utf8_byte_t utf8_due_q[$];

  // predictor copy of the pairing state
  logic [23:0] held_bytes = '0;
  logic [1:0]  held_count = '0;

  logic [31:0] cycles = '0;
  int          items_taken = 0;
  int          errors = 0;
  logic        took_in = 1'b0;   // an item was accepted at the last rising edge
  logic        took_out = 1'b0;  // a result was accepted at the last rising edge
  logic [1:0]  in_gap = '0;
  logic [1:0]  out_stall = '0;
  int unsigned stall_draw;
  logic        quiet;

  // one window in four runs with no idling on either side
  assign quiet = (cycles[9:8] == 2'b11);

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic void due_byte(input logic [7:0] b);
    utf8_byte_t r;
    r.b = b;
    r.run_last = 1'b0;
    r.stream_done = 1'b0;
    utf8_due_q.push_back(r);
  endfunction

  // utf-8 encoding; out-of-range values collapse to the replacement char
  function automatic void due_code_point(input logic [21:0] cp_in);
    logic [21:0] cp;
    cp = cp_in;
    if (cp <= 22'h00007F) begin
      due_byte({1'b0, cp[6:0]});
    end else if (cp <= 22'h0007FF) begin
      due_byte({3'b110, cp[10:6]});
      due_byte({2'b10, cp[5:0]});
    end else begin
      if (cp > MAX_SCALAR) cp = REPLACEMENT;
      // surrogate values fall through here and get three bytes as well
      if (cp <= 22'h00FFFF) begin
        due_byte({4'b1110, cp[15:12]});
        due_byte({2'b10, cp[11:6]});
        due_byte({2'b10, cp[5:0]});
      end else begin
        due_byte({5'b11110, cp[20:18]});
        due_byte({2'b10, cp[17:12]});
        due_byte({2'b10, cp[11:6]});
        due_byte({2'b10, cp[5:0]});
      end
    end
  endfunction

  function automatic void transcode_byte(input logic [7:0] b, input logic eos);
    int          due_start;
    logic [15:0] unit_a;
    logic [15:0] unit_b;
    logic [15:0] hi_off;
    utf8_byte_t  tail;
    due_start = utf8_due_q.size();
    case (held_count)
      2'd0: begin
        // end flag on the first byte of a unit: lone trailing byte
        if (eos) begin
          due_code_point(REPLACEMENT);
        end else begin
          held_bytes = {16'h0000, b};
          held_count = 2'd1;
        end
      end
      2'd1: begin
        unit_a = {held_bytes[7:0], b};
        if (unit_a < HIGH_FIRST || unit_a > SURR_LAST || eos) begin
          due_code_point({6'h00, unit_a});
          held_bytes = '0;
          held_count = 2'd0;
        end else begin
          // surrogate with more bytes possible: wait for the partner unit
          held_bytes = {8'h00, unit_a};
          held_count = 2'd2;
        end
      end
      2'd2: begin
        if (eos) begin
          // surrogate alone, then the dangling byte as a replacement
          due_code_point({6'h00, held_bytes[15:0]});
          due_code_point(REPLACEMENT);
        end else begin
          held_bytes = {held_bytes[15:0], b};
          held_count = 2'd3;
        end
      end
      default: begin
        // pair combine; the partner's range is never checked
        unit_a = held_bytes[23:8];
        unit_b = {held_bytes[7:0], b};
        hi_off = unit_a - HIGH_FIRST;
        due_code_point((22'(hi_off) << 10) + 22'(unit_b) + PAIR_ADJUST);
        held_bytes = '0;
        held_count = 2'd0;
      end
    endcase
    if (eos) begin
      held_bytes = '0;
      held_count = 2'd0;
    end
    if (utf8_due_q.size() > due_start) begin
      tail = utf8_due_q.pop_back();
      tail.run_last = 1'b1;
      tail.stream_done = eos;
      utf8_due_q.push_back(tail);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // sampling at the rising edge: predict on accepted items, check results
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    utf8_byte_t want;
    cycles <= cycles + 1;
    took_in <= rst_n && push && !full;
    took_out <= rst_n && pop && !empty;
    if (rst_n && push && !full) begin
      transcode_byte(in_byte, in_end_of_stream);
      items_taken <= items_taken + 1;
    end
    if (rst_n && pop && !empty) begin
      if (utf8_due_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual byte %h last %b done %b",
                 $time, out_utf8_byte, out_run_last, out_stream_done);
        errors++;
      end else begin
        want = utf8_due_q.pop_front();
        if (out_utf8_byte !== want.b) begin
          $display("%0t: utf8_byte mismatch: expected %h, actual %h",
                   $time, want.b, out_utf8_byte);
          errors++;
        end
        if (out_run_last !== want.run_last) begin
          $display("%0t: run_last mismatch: expected %b, actual %b",
                   $time, want.run_last, out_run_last);
          errors++;
        end
        if (out_stream_done !== want.stream_done) begin
          $display("%0t: stream_done mismatch: expected %b, actual %b",
                   $time, want.stream_done, out_stream_done);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driving at the falling edge
  // ---------------------------------------------------------------------------

  // sender: present the next byte once the current one is taken and the gap ran out
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      in_byte <= 8'h00;
      in_end_of_stream <= 1'b0;
      in_gap <= '0;
    end else if (!push || took_in) begin
      if (in_gap != 0) begin
        push <= 1'b0;
        in_gap <= in_gap - 1'b1;
      end else if (u16_stream_q.size() != 0 &&
                   !(u16_stream_q[0].drain && utf8_due_q.size() != 0)) begin
        push <= 1'b1;
        in_byte <= u16_stream_q[0].b;
        in_end_of_stream <= u16_stream_q[0].eos;
        void'(u16_stream_q.pop_front());
        in_gap <= quiet ? 2'd0 : 2'($urandom_range(0, 3));
      end else begin
        push <= 1'b0;
      end
    end
  end

  // receiver: after each taken result, stall a random number of cycles
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
      out_stall <= '0;
    end else if (took_out) begin
      stall_draw = quiet ? 0 : $urandom_range(0, 3);
      pop <= (stall_draw == 0);
      out_stall <= (stall_draw == 0) ? 2'd0 : 2'(stall_draw - 1);
    end else if (!pop) begin
      if (out_stall != 0) out_stall <= out_stall - 1'b1;
      else pop <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  function automatic void add_byte(input logic [7:0] b, input logic eos,
                                   input logic drain);
    u16_byte_t it;
    it.b = b;
    it.eos = eos;
    it.drain = drain;
    u16_stream_q.push_back(it);
  endfunction

  function automatic void add_unit(input logic [15:0] u, input logic eos);
    add_byte(u[15:8], 1'b0, 1'b0);
    add_byte(u[7:0], eos, 1'b0);
  endfunction

  // raise the end flag on the byte queued last
  function automatic void close_string();
    u16_byte_t it;
    it = u16_stream_q.pop_back();
    it.eos = 1'b1;
    u16_stream_q.push_back(it);
  endfunction

  // timeout watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    int          total;
    int          units;
    logic [15:0] u;
    logic [15:0] partner;

    // directed: encoding length boundaries, ending the string on a two-byte unit
    add_unit(16'h0000, 1'b0);
    add_unit(16'h007F, 1'b0);
    add_unit(16'h0080, 1'b0);
    add_unit(16'h07FF, 1'b0);
    add_unit(16'h0800, 1'b0);
    add_unit(16'hFFFF, 1'b1);
    // well-formed pairs at both ends of the supplementary range
    add_unit(16'hD800, 1'b0);
    add_unit(16'hDC00, 1'b0);
    add_unit(16'hDBFF, 1'b0);
    add_unit(16'hDFFF, 1'b1);
    // odd pair beyond 10ffff turns into the replacement char
    add_unit(16'hDFFF, 1'b0);
    add_unit(16'hFFFF, 1'b0);
    // odd pair landing on a surrogate value, encoded as three bytes
    add_unit(16'hD800, 1'b0);
    add_unit(16'hB400, 1'b1);
    // lone final byte
    add_byte(8'h41, 1'b1, 1'b0);
    // surrogate at end of string, alone
    add_unit(16'hD800, 1'b1);
    // surrogate then one dangling byte: six results from the last item
    add_unit(16'hDBFF, 1'b0);
    add_byte(8'h12, 1'b1, 1'b1);

    // random strings, mostly well-formed units with random content
    while (u16_stream_q.size() < 160) begin
      units = $urandom_range(1, 6);
      // let the output side drain completely every so often
      add_byte(8'($urandom_range(0, 255)), 1'b0, ($urandom_range(0, 7) == 0));
      add_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      repeat (units) begin
        case ($urandom_range(0, 9))
          0, 1: add_unit(16'($urandom_range(0, 16'h007F)), 1'b0);
          2:    add_unit(16'($urandom_range(16'h0080, 16'h07FF)), 1'b0);
          3: begin
            if ($urandom_range(0, 1) == 0) u = 16'($urandom_range(16'h0800, 16'hD7FF));
            else u = 16'($urandom_range(16'hE000, 16'hFFFF));
            add_unit(u, 1'b0);
          end
          4, 5, 6: begin
            add_unit(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0);
            add_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), 1'b0);
          end
          7: begin
            // any surrogate with any partner
            u = 16'($urandom_range(16'hD800, 16'hDFFF));
            partner = 16'($urandom_range(0, 16'hFFFF));
            add_unit(u, 1'b0);
            add_unit(partner, 1'b0);
          end
          8: add_unit(16'($urandom_range(0, 16'hFFFF)), 1'b0);
          default: add_unit(16'($urandom_range(16'hD800, 16'hDFFF)), 1'b0);
        endcase
      end
      // sometimes a stray byte before the end flag
      if ($urandom_range(0, 5) == 0) add_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      close_string();
    end
    total = u16_stream_q.size();

    // hold reset, then release it at a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (items_taken < total || utf8_due_q.size() != 0) @(posedge clk);
    // anything arriving now is an extra result
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
